@@ rtl/lpp_pkg.sv @@
`default_nettype none

package lpp_pkg;

  localparam int KIND_W    = 2;
  localparam int PAT_W     = 3;
  localparam int BPOS_W    = 6;
  localparam int FPOS_W    = 4;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BASE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLASH = 2'd2;

  localparam logic [PAT_W-1:0] PAT_OFF      = 3'd0;
  localparam logic [PAT_W-1:0] PAT_MARK1    = 3'd1;
  localparam logic [PAT_W-1:0] PAT_MARK2    = 3'd2;
  localparam logic [PAT_W-1:0] PAT_UNCAL    = 3'd3;
  localparam logic [PAT_W-1:0] PAT_IDENTIFY = 3'd4;
  localparam logic [PAT_W-1:0] PAT_ACK      = 3'd5;
  localparam logic [PAT_W-1:0] PAT_ERROR    = 3'd6;

  localparam logic [FPOS_W-1:0] ACK_TICKS   = 4'd12;
  localparam logic [FPOS_W-1:0] ERROR_TICKS = 4'd14;

  // LED level of a pattern at a position
  function automatic logic level_at(input logic [PAT_W-1:0] pat,
                                    input logic [BPOS_W-1:0] t);
    logic lvl;
    case (pat)
      PAT_MARK1:    lvl = (t < 6'd10) || (t >= 6'd20 && t < 6'd30) ||
                          (t >= 6'd40 && t < 6'd50) || (t >= 6'd60);
      PAT_MARK2:    lvl = ~t[1];
      PAT_UNCAL:    lvl = (t == 6'd0) || (t == 6'd1) || (t == 6'd4) || (t == 6'd5);
      PAT_IDENTIFY: lvl = ~t[0];
      PAT_ACK:      lvl = (t < 6'd12) && ~t[1];
      PAT_ERROR:    lvl = (t >= 6'd4) && (t < 6'd14) && ~t[0];
      default:      lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

@@ rtl/led_pattern_player_top.sv @@
// Status LED pattern player.
// Input channel (in_valid/in_ready, kind, pattern): one item per cycle at most.
//   kind tick advances the active pattern and yields one result; kind set-base
//   and kind flash only update state and yield nothing; kind three is dropped.
// Output channel (out_valid/out_ready, led_level): one item per tick.
// Order: an accepted item is held in the input register and worked from there;
//   a tick's result is registered in the output register (led_level, out_valid).
// Throughput: one item per cycle, limited only by the output register when
//   the receiver stalls.
// Stall: while out_valid is held and out_ready low, a tick waiting in the
//   input register holds, and in_ready drops; non-tick items still drain.
// Reset (rst, synchronous): both registers empty, base pattern off, no
//   transient, positions zero.
// Base frame length is FRAME_TICKS ticks (20..64).
`default_nettype none

module led_pattern_player_top
  import lpp_pkg::*;
#(
  parameter int FRAME_TICKS = 60
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [PAT_W-1:0]  pattern,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   led_level
);

  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [PAT_W-1:0]  s1_pattern;
  logic              s1_go;
  logic              s1_tick;
  logic              out_free;
  logic              level;

  assign out_free = !out_valid || out_ready;
  assign s1_tick  = (s1_kind == KIND_TICK);
  assign s1_go    = s1_valid && (!s1_tick || out_free);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind    <= kind;
      s1_pattern <= pattern;
    end
  end

  lpp_state #(
    .FRAME_TICKS(FRAME_TICKS)
  ) u_state (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_go),
    .kind   (s1_kind),
    .pattern(s1_pattern),
    .level  (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_tick) begin
      led_level <= level;
    end
  end

`ifndef SYNTHESIS
  a_tick_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_tick && out_valid && !out_ready |-> !in_ready)
    else $error("tick item not held while output stalled");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_go && s1_tick))
    else $error("result item without a tick");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("registers not empty after reset");
`endif

endmodule

`default_nettype wire

@@ rtl/lpp_state.sv @@
`default_nettype none

module lpp_state
  import lpp_pkg::*;
#(
  parameter int FRAME_TICKS = 60
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [PAT_W-1:0]  pattern,
  output logic                   level
);

  localparam logic [BPOS_W-1:0] BPOS_LAST = BPOS_W'(FRAME_TICKS - 1);

  logic [PAT_W-1:0]  base_pattern, base_pattern_next;
  logic [PAT_W-1:0]  flash_pattern, flash_pattern_next;
  logic [BPOS_W-1:0] base_position, base_position_next;
  logic [FPOS_W-1:0] flash_position, flash_position_next;
  logic [FPOS_W-1:0] fpos_inc;
  logic              flash_active;

  assign flash_active = (flash_pattern != PAT_OFF);
  assign fpos_inc     = flash_position + 1'b1;

  always_comb begin
    if (flash_active) begin
      level = level_at(flash_pattern, {{(BPOS_W-FPOS_W){1'b0}}, flash_position});
    end else begin
      level = level_at(base_pattern, base_position);
    end
  end

  always_comb begin
    base_pattern_next   = base_pattern;
    flash_pattern_next  = flash_pattern;
    base_position_next  = base_position;
    flash_position_next = flash_position;
    case (kind)
      KIND_BASE: begin
        if (pattern != base_pattern) begin
          base_pattern_next  = pattern;
          base_position_next = '0;
        end
      end
      KIND_FLASH: begin
        if (pattern == PAT_ACK || pattern == PAT_ERROR) begin
          flash_pattern_next  = pattern;
          flash_position_next = '0;
        end
      end
      KIND_TICK: begin
        if (flash_active) begin
          flash_position_next = fpos_inc;
          if ((flash_pattern == PAT_ACK && fpos_inc >= ACK_TICKS) ||
              (flash_pattern == PAT_ERROR && fpos_inc >= ERROR_TICKS)) begin
            flash_pattern_next = PAT_OFF;
          end
        end else if (base_position == BPOS_LAST) begin
          base_position_next = '0;
        end else begin
          base_position_next = base_position + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_pattern   <= PAT_OFF;
      flash_pattern  <= PAT_OFF;
      base_position  <= '0;
      flash_position <= '0;
    end else if (step) begin
      base_pattern   <= base_pattern_next;
      flash_pattern  <= flash_pattern_next;
      base_position  <= base_position_next;
      flash_position <= flash_position_next;
    end
  end

endmodule

`default_nettype wire
